@@ rtl/bb_pkg.sv @@
// shared types, constants and codes of the box blur block
package bb_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned PIX_W         = 8;
  localparam int unsigned RGB_W         = 3 * PIX_W;
  localparam int unsigned WIDTH_REG_W   = 11;
  localparam int unsigned HEIGHT_REG_W  = 13;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 13;
  localparam int unsigned SUM_W         = 12;
  localparam int unsigned CNT_W         = 4;
  localparam int unsigned NUM_W         = 13;
  localparam int unsigned DEN_W         = 5;
  localparam int unsigned QSTEP_W       = 3;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = WIDTH_REG_W'(640);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = HEIGHT_REG_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_SUM  = 5'b00100,
    S_LOAD = 5'b01000,
    S_DIV  = 5'b10000
  } state_e;

  typedef logic [2:0][NUM_W-1:0] num_t;
  typedef logic [2:0][PIX_W-1:0] quot_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

@@ rtl/bb_pix_in_if.sv @@
// input pixel channel
interface bb_pix_in_if;
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic [bb_pkg::PIX_W-1:0] in_red;
  logic [bb_pkg::PIX_W-1:0] in_green;
  logic [bb_pkg::PIX_W-1:0] in_blue;

  modport source (output valid, mode, in_red, in_green, in_blue, input ready);
  modport sink (input valid, mode, in_red, in_green, in_blue, output ready);
endinterface

@@ rtl/bb_pix_out_if.sv @@
// output pixel channel
interface bb_pix_out_if;
  logic                    valid;
  logic                    ready;
  logic [bb_pkg::PIX_W-1:0] out_red;
  logic [bb_pkg::PIX_W-1:0] out_green;
  logic [bb_pkg::PIX_W-1:0] out_blue;
  logic                    frame_end;

  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

@@ rtl/bb_cfg_if.sv @@
// configuration write channel
interface bb_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bb_pkg::CFG_IDX_W-1:0]  index;
  logic [bb_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/bb_line_mem.sv @@
// pixel history memory, one write and one registered read port
module bb_line_mem #(
  parameter int unsigned ADDR_W = 11
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [ADDR_W-1:0]         waddr_i,
  input  logic [bb_pkg::RGB_W-1:0]  wdata_i,
  input  logic                      re_i,
  input  logic [ADDR_W-1:0]         raddr_i,
  output logic [bb_pkg::RGB_W-1:0]  rdata_o
);
  import bb_pkg::*;

  localparam int unsigned Depth = 2 ** ADDR_W;

  logic [RGB_W-1:0] mem [Depth];
  logic [RGB_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ rtl/bb_div.sv @@
// restoring divider, one quotient bit per cycle for all three colors
module bb_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  bb_pkg::num_t              num_i,
  input  logic [bb_pkg::DEN_W-1:0]  den_i,
  output bb_pkg::quot_t             quot_o,
  output logic                      done_o
);
  import bb_pkg::*;

  num_t                rem_q, rem_d;
  quot_t               quot_q, quot_d;
  logic [DEN_W-1:0]    den_q;
  logic [QSTEP_W-1:0]  step_q, step_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [NUM_W-1:0]    trial;

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = done_q;
    trial  = NUM_W'(den_q) << step_q;
    if (start_i) begin
      rem_d  = num_i;
      quot_d = '0;
      step_d = '1;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      for (int c = 0; c < 3; c++) begin
        if (rem_q[c] >= trial) begin
          rem_d[c]          = rem_q[c] - trial;
          quot_d[c][step_q] = 1'b1;
        end
      end
      step_d = step_q - QSTEP_W'(1);
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign quot_o = quot_q;
  assign done_o = done_q;
endmodule

@@ rtl/box_blur_3x3_clipped_edges.sv @@
// top level of the clipped-edge 3x3 box blur
//
// Pixels of one frame enter on in_chan in raster order (mode 0); after the
// last pixel, drain transactions (mode 1) flush the outstanding results.
// Results leave on out_chan, frame_end marking the last one of a frame.
// The result of pixel p comes with the transaction that carries pixel
// p+width+1, or with a drain transaction once the frame is complete.
// A transaction that yields no result ends with its accepting cycle; one
// that does steps through the neighbor positions in S_RD, reading the
// history memory for those inside the frame, then S_SUM, which finishes
// the sums, and S_LOAD, and waits for the divider, which produces one
// quotient bit per cycle and then flags done. in_chan takes the next
// transaction as soon as the previous one has placed its result in the
// output register, so a waiting result does not hold the input back; a
// stalled receiver stops the block only when a second result is ready.
// cfg_chan is always ready; a write of frame_width or frame_height
// restarts the frame. Reset sets 640 by 480 and restarts the frame;
// the history memory needs no clearing.
module box_blur_3x3_clipped_edges #(
  parameter int unsigned MAX_WIDTH = bb_pkg::MAX_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bb_pix_in_if.sink    in_chan,
  bb_pix_out_if.source out_chan,
  bb_cfg_if.sink       cfg_chan
);
  import bb_pkg::*;

  localparam int unsigned AddrW = $clog2(2 * MAX_WIDTH + 3);
  localparam int unsigned WeW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ColW  = $clog2(MAX_WIDTH);

  state_e                  state_q, state_d;
  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;
  logic [WeW-1:0]          w_eff;
  logic [HEIGHT_REG_W-1:0] h_eff;

  logic [HEIGHT_REG_W-1:0] in_row_q, out_row_q;
  logic [ColW-1:0]         in_col_q, out_col_q;
  logic [AddrW-1:0]        in_ptr_q, out_ptr_q, rbase_q;
  logic [1:0]              tr_q, tc_q;
  logic                    act_q;
  logic [CNT_W-1:0]        n_q;
  logic [2:0][SUM_W-1:0]   sum_q;
  logic                    fe_q;

  logic                    in_acc, cfg_acc, out_acc, slot_free;
  logic                    received, pix_emit, tap_ok;
  logic [AddrW-1:0]        raddr;
  logic [RGB_W-1:0]        rdata;
  logic [WeW-1:0]          in_col_nx, out_col_nx;
  logic [HEIGHT_REG_W:0]   out_row_nx;
  num_t                    div_num;
  quot_t                   div_quot;
  div_ctl_t                div_ctl;

  logic [PIX_W-1:0]        out_red_q, out_green_q, out_blue_q;
  logic                    out_fe_q, out_valid_q;

  always_comb begin
    if (width_q == '0) begin
      w_eff = WeW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WeW'(MAX_WIDTH);
    end else begin
      w_eff = WeW'(width_q);
    end
    h_eff = (height_q == '0) ? HEIGHT_REG_W'(1) : height_q;
  end

  assign in_acc    = in_chan.valid && in_chan.ready;
  assign cfg_acc   = cfg_chan.valid && cfg_chan.ready;
  assign out_acc   = out_valid_q && out_chan.ready;
  assign slot_free = !out_valid_q || out_chan.ready;
  assign received  = in_row_q >= h_eff;
  assign pix_emit  = (in_row_q != '0) && ((in_row_q >= HEIGHT_REG_W'(2)) || (in_col_q != '0));
  assign in_col_nx = WeW'(in_col_q) + WeW'(1);
  assign out_col_nx = WeW'(out_col_q) + WeW'(1);
  assign out_row_nx = {1'b0, out_row_q} + (HEIGHT_REG_W + 1)'(1);

  assign in_chan.ready  = (state_q == S_IDLE);
  assign cfg_chan.ready = 1'b1;

  // neighbor inside the frame
  always_comb begin
    tap_ok = 1'b1;
    if (tr_q == 2'd0 && out_row_q == '0) tap_ok = 1'b0;
    if (tr_q == 2'd2 && out_row_nx >= {1'b0, h_eff}) tap_ok = 1'b0;
    if (tc_q == 2'd0 && out_col_q == '0) tap_ok = 1'b0;
    if (tc_q == 2'd2 && out_col_nx >= w_eff) tap_ok = 1'b0;
  end

  assign raddr = rbase_q + AddrW'(tc_q) - AddrW'(1);

  bb_line_mem #(
    .ADDR_W (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (in_acc && !in_chan.mode && !received),
    .waddr_i (in_ptr_q),
    .wdata_i ({in_chan.in_red, in_chan.in_green, in_chan.in_blue}),
    .re_i    ((state_q == S_RD) && tap_ok),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      div_num[c] = {sum_q[c], 1'b0} + NUM_W'(n_q);
    end
  end

  assign div_ctl.start = (state_q == S_LOAD);

  bb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_ctl.start),
    .num_i   (div_num),
    .den_i   ({n_q, 1'b0}),
    .quot_o  (div_quot),
    .done_o  (div_ctl.done)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (received || (!in_chan.mode && pix_emit))) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (tr_q == 2'd2 && tc_q == 2'd2) state_d = S_SUM;
      end
      S_SUM:  state_d = S_LOAD;
      S_LOAD: state_d = S_DIV;
      S_DIV: begin
        if (div_ctl.done && slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= WIDTH_RST;
      height_q    <= HEIGHT_RST;
      in_row_q    <= '0;
      in_col_q    <= '0;
      in_ptr_q    <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_ptr_q   <= '0;
      tr_q        <= '0;
      tc_q        <= '0;
      act_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      act_q   <= (state_q == S_RD) && tap_ok;

      if (state_q == S_IDLE && in_acc && !in_chan.mode && !received) begin
        in_ptr_q <= in_ptr_q + AddrW'(1);
        if (in_col_nx >= w_eff) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + HEIGHT_REG_W'(1);
        end else begin
          in_col_q <= in_col_q + ColW'(1);
        end
      end

      if (state_q == S_IDLE) begin
        tr_q <= '0;
        tc_q <= '0;
      end else if (state_q == S_RD) begin
        if (tc_q == 2'd2) begin
          tc_q <= '0;
          tr_q <= tr_q + 2'd1;
        end else begin
          tc_q <= tc_q + 2'd1;
        end
      end

      if (state_q == S_LOAD) begin
        out_ptr_q <= out_ptr_q + AddrW'(1);
        if (out_col_nx >= w_eff) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + HEIGHT_REG_W'(1);
          if (out_row_nx >= {1'b0, h_eff}) begin
            in_row_q  <= '0;
            in_col_q  <= '0;
            in_ptr_q  <= '0;
            out_row_q <= '0;
            out_ptr_q <= '0;
          end
        end else begin
          out_col_q <= out_col_q + ColW'(1);
        end
      end

      if (cfg_acc && (cfg_chan.index == REG_FRAME_WIDTH ||
                      cfg_chan.index == REG_FRAME_HEIGHT)) begin
        if (cfg_chan.index == REG_FRAME_WIDTH) begin
          width_q <= cfg_chan.data[WIDTH_REG_W-1:0];
        end else begin
          height_q <= cfg_chan.data;
        end
        in_row_q  <= '0;
        in_col_q  <= '0;
        in_ptr_q  <= '0;
        out_row_q <= '0;
        out_col_q <= '0;
        out_ptr_q <= '0;
      end

      if (state_q == S_DIV && div_ctl.done && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      rbase_q <= out_ptr_q - AddrW'(w_eff);
      sum_q   <= '0;
      n_q     <= '0;
      fe_q    <= ({1'b0, out_row_q} == {1'b0, h_eff} - (HEIGHT_REG_W + 1)'(1)) &&
                 (out_col_nx == w_eff);
    end else begin
      if (state_q == S_RD && tc_q == 2'd2) begin
        rbase_q <= rbase_q + AddrW'(w_eff);
      end
      if (act_q) begin
        sum_q[0] <= sum_q[0] + SUM_W'(rdata[RGB_W-1 -: PIX_W]);
        sum_q[1] <= sum_q[1] + SUM_W'(rdata[PIX_W +: PIX_W]);
        sum_q[2] <= sum_q[2] + SUM_W'(rdata[0 +: PIX_W]);
        n_q      <= n_q + CNT_W'(1);
      end
    end
    if (state_q == S_DIV && div_ctl.done && slot_free) begin
      out_red_q   <= div_quot[0];
      out_green_q <= div_quot[1];
      out_blue_q  <= div_quot[2];
      out_fe_q    <= fe_q;
    end
  end

  assign out_chan.valid     = out_valid_q;
  assign out_chan.out_red   = out_red_q;
  assign out_chan.out_green = out_green_q;
  assign out_chan.out_blue  = out_blue_q;
  assign out_chan.frame_end = out_fe_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOAD |-> n_q >= CNT_W'(1) && n_q <= CNT_W'(9))
    else $error("neighbor count out of range");

  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WeW'(in_col_q) < w_eff && WeW'(out_col_q) < w_eff)
    else $error("column counter beyond frame width");

  a_result_from_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DIV))
    else $error("result loaded outside divide phase");

  a_emit_starts_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE && in_acc && received |=> state_q == S_RD)
    else $error("drain transaction did not start a result");
endmodule
